// ===== rtl/scs1_pkg.sv =====
// shared types, constants and translation tables for the scan code decoder
`timescale 1ns / 1ps
`default_nettype none

package scs1_pkg;

  typedef enum logic [1:0] {
    FN_SCAN  = 2'd0,
    FN_QUERY = 2'd1,
    FN_XLAT  = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  localparam int unsigned KeyBits  = 7;
  localparam int unsigned NumKeys  = 1 << KeyBits;
  localparam int unsigned DataBits = 16;
  localparam int unsigned CharBits = 7;

  localparam logic [7:0]          PrefixByte = 8'hE0;
  localparam logic [KeyBits-1:0]  KcLshift   = 7'h2A;
  localparam logic [KeyBits-1:0]  KcRshift   = 7'h36;
  localparam logic [KeyBits-1:0]  KcCaps     = 7'h3A;
  localparam logic [KeyBits-1:0]  KcEnter    = 7'h1C;
  localparam logic [KeyBits-1:0]  KcBksp     = 7'h0E;
  localparam logic [8:0]          ExtMark    = 9'h1C0;
  localparam logic [CharBits-1:0] ChBksp     = 7'h08;
  localparam logic [CharBits-1:0] ChEnter    = 7'h0A;

  typedef struct packed {
    logic               en;
    logic [KeyBits-1:0] addr;
    logic               val;
  } map_wr_t;

  function automatic logic [CharBits-1:0] rom_plain(input logic [KeyBits-1:0] kc);
    logic [CharBits-1:0] ch;
    unique case (kc)
      7'd1:    ch = 7'h1B;
      7'd2:    ch = 7'h31;
      7'd3:    ch = 7'h32;
      7'd4:    ch = 7'h33;
      7'd5:    ch = 7'h34;
      7'd6:    ch = 7'h35;
      7'd7:    ch = 7'h36;
      7'd8:    ch = 7'h37;
      7'd9:    ch = 7'h38;
      7'd10:   ch = 7'h39;
      7'd11:   ch = 7'h30;
      7'd12:   ch = 7'h2D;
      7'd13:   ch = 7'h3D;
      7'd14:   ch = 7'h08;
      7'd15:   ch = 7'h09;
      7'd16:   ch = 7'h71;
      7'd17:   ch = 7'h77;
      7'd18:   ch = 7'h65;
      7'd19:   ch = 7'h72;
      7'd20:   ch = 7'h74;
      7'd21:   ch = 7'h79;
      7'd22:   ch = 7'h75;
      7'd23:   ch = 7'h69;
      7'd24:   ch = 7'h6F;
      7'd25:   ch = 7'h70;
      7'd26:   ch = 7'h5B;
      7'd27:   ch = 7'h5D;
      7'd28:   ch = 7'h0A;
      7'd30:   ch = 7'h61;
      7'd31:   ch = 7'h73;
      7'd32:   ch = 7'h64;
      7'd33:   ch = 7'h66;
      7'd34:   ch = 7'h67;
      7'd35:   ch = 7'h68;
      7'd36:   ch = 7'h6A;
      7'd37:   ch = 7'h6B;
      7'd38:   ch = 7'h6C;
      7'd39:   ch = 7'h3B;
      7'd40:   ch = 7'h27;
      7'd41:   ch = 7'h60;
      7'd43:   ch = 7'h5C;
      7'd44:   ch = 7'h7A;
      7'd45:   ch = 7'h78;
      7'd46:   ch = 7'h63;
      7'd47:   ch = 7'h76;
      7'd48:   ch = 7'h62;
      7'd49:   ch = 7'h6E;
      7'd50:   ch = 7'h6D;
      7'd51:   ch = 7'h2C;
      7'd52:   ch = 7'h2E;
      7'd53:   ch = 7'h2F;
      7'd55:   ch = 7'h2A;
      7'd57:   ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

  function automatic logic [CharBits-1:0] rom_upper(input logic [KeyBits-1:0] kc);
    logic [CharBits-1:0] ch;
    unique case (kc)
      7'd1:    ch = 7'h1B;
      7'd2:    ch = 7'h21;
      7'd3:    ch = 7'h40;
      7'd4:    ch = 7'h23;
      7'd5:    ch = 7'h24;
      7'd6:    ch = 7'h25;
      7'd7:    ch = 7'h5E;
      7'd8:    ch = 7'h26;
      7'd9:    ch = 7'h2A;
      7'd10:   ch = 7'h28;
      7'd11:   ch = 7'h29;
      7'd12:   ch = 7'h5F;
      7'd13:   ch = 7'h2B;
      7'd14:   ch = 7'h08;
      7'd15:   ch = 7'h09;
      7'd16:   ch = 7'h51;
      7'd17:   ch = 7'h57;
      7'd18:   ch = 7'h45;
      7'd19:   ch = 7'h52;
      7'd20:   ch = 7'h54;
      7'd21:   ch = 7'h59;
      7'd22:   ch = 7'h55;
      7'd23:   ch = 7'h49;
      7'd24:   ch = 7'h4F;
      7'd25:   ch = 7'h50;
      7'd26:   ch = 7'h7B;
      7'd27:   ch = 7'h7D;
      7'd28:   ch = 7'h0A;
      7'd30:   ch = 7'h41;
      7'd31:   ch = 7'h53;
      7'd32:   ch = 7'h44;
      7'd33:   ch = 7'h46;
      7'd34:   ch = 7'h47;
      7'd35:   ch = 7'h48;
      7'd36:   ch = 7'h4A;
      7'd37:   ch = 7'h4B;
      7'd38:   ch = 7'h4C;
      7'd39:   ch = 7'h3A;
      7'd40:   ch = 7'h22;
      7'd41:   ch = 7'h7E;
      7'd43:   ch = 7'h7C;
      7'd44:   ch = 7'h5A;
      7'd45:   ch = 7'h58;
      7'd46:   ch = 7'h43;
      7'd47:   ch = 7'h56;
      7'd48:   ch = 7'h42;
      7'd49:   ch = 7'h4E;
      7'd50:   ch = 7'h4D;
      7'd51:   ch = 7'h3C;
      7'd52:   ch = 7'h3E;
      7'd53:   ch = 7'h3F;
      7'd55:   ch = 7'h2A;
      7'd57:   ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scs1_keymap.sv =====
// per-key pressed map: memory with registered read, reset valid bits and write forwarding
`timescale 1ns / 1ps
`default_nettype none

module scs1_keymap (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        rd_en_i,
  input  wire logic [scs1_pkg::KeyBits-1:0] rd_addr_i,
  input  wire scs1_pkg::map_wr_t           wr_i,
  output logic                             rd_pressed_o
);
  import scs1_pkg::*;

  logic                key_mem_q [NumKeys];
  logic [NumKeys-1:0]  vld_q;
  logic [NumKeys-1:0]  vld_d;
  logic                rd_data_q;
  logic                rd_vld_q;
  logic                rd_vld_d;
  logic                fwd;

  assign fwd = wr_i.en && (wr_i.addr == rd_addr_i);

  always_comb begin
    vld_d = vld_q;
    if (wr_i.en) begin
      vld_d[wr_i.addr] = 1'b1;
    end
    rd_vld_d = fwd ? 1'b1 : vld_q[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_mem_q[wr_i.addr] <= wr_i.val;
    end
    if (rd_en_i) begin
      rd_data_q <= fwd ? wr_i.val : key_mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (rd_en_i) begin
        rd_vld_q <= rd_vld_d;
      end
    end
  end

  assign rd_pressed_o = rd_vld_q && rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/scs1_xlat.sv =====
// key code to ascii translation with fixed backspace and enter
`timescale 1ns / 1ps
`default_nettype none

module scs1_xlat (
  input  wire logic [scs1_pkg::DataBits-1:0] code_i,
  input  wire logic                          upper_i,
  output logic      [scs1_pkg::CharBits-1:0] char_o
);
  import scs1_pkg::*;

  logic [KeyBits-1:0] kc;
  logic               in_range;

  assign kc       = code_i[KeyBits-1:0];
  assign in_range = (code_i[DataBits-1:KeyBits] == '0);

  always_comb begin
    priority if (!in_range) begin
      char_o = '0;
    end else if (kc == KcBksp) begin
      char_o = ChBksp;
    end else if (kc == KcEnter) begin
      char_o = ChEnter;
    end else if (upper_i) begin
      char_o = rom_upper(kc);
    end else begin
      char_o = rom_plain(kc);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scan_code_set1_keyboard_decoder.sv =====
// Scan code set 1 keyboard decoder top level.
// Input channel: func_i and data_i with in_valid_i, in_stall_o.
// Output channel: one result item per input item on event_valid_o,
// event_break_o, event_code_o, pressed_o and ascii_char_o with
// out_valid_o, out_stall_i.
// func 0 feeds a raw scan byte, func 1 asks whether a key is held,
// func 2 translates a key code to ascii; func 3 gives an all-zero result.
// An item is captured into an input register together with the registered
// read of the pressed map, worked on combinationally and written into the
// result register, which drives out_valid_o.
// One item is accepted every cycle while the output is not stalled; the
// pressed map read is bypassed from the write of the item ahead.
// Reset clears shift, caps, the extended prefix flag, the map valid bits
// and both pipeline stages; no clearing pass is needed.
// While out_stall_i holds a result, that result stays put, the input
// register keeps one more item, and in_stall_o rises once both are full.
`timescale 1ns / 1ps
`default_nettype none

module scan_code_set1_keyboard_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [scs1_pkg::DataBits-1:0] data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               event_valid_o,
  output logic                               event_break_o,
  output logic      [scs1_pkg::DataBits-1:0] event_code_o,
  output logic                               pressed_o,
  output logic      [scs1_pkg::CharBits-1:0] ascii_char_o
);
  import scs1_pkg::*;

  logic                 s1_valid_q;
  func_e                s1_func_q;
  logic [DataBits-1:0]  s1_data_q;
  logic                 out_valid_q;
  logic                 shift_q, shift_d;
  logic                 caps_q, caps_d;
  logic                 ext_q, ext_d;
  logic                 out_free;
  logic                 fire;
  logic                 accept;
  logic [7:0]           scan_byte;
  logic [KeyBits-1:0]   kc;
  logic                 brk;
  logic                 is_prefix;
  logic                 rd_pressed;
  logic [CharBits-1:0]  xlat_char;
  map_wr_t              map_wr;

  logic                 ev_valid_d, ev_break_d, pressed_d;
  logic [DataBits-1:0]  ev_code_d;
  logic                 ev_valid_q, ev_break_q, pressed_q;
  logic [DataBits-1:0]  ev_code_q;
  logic [CharBits-1:0]  ascii_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign scan_byte = s1_data_q[7:0];
  assign kc        = scan_byte[KeyBits-1:0];
  assign brk       = scan_byte[7];
  assign is_prefix = (scan_byte == PrefixByte);

  scs1_keymap u_keymap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_addr_i    (data_i[KeyBits-1:0]),
    .wr_i         (map_wr),
    .rd_pressed_o (rd_pressed)
  );

  scs1_xlat u_xlat (
    .code_i  (s1_data_q),
    .upper_i (shift_q ^ caps_q),
    .char_o  (xlat_char)
  );

  always_comb begin
    shift_d    = shift_q;
    caps_d     = caps_q;
    ext_d      = ext_q;
    map_wr     = '{en: 1'b0, addr: kc, val: !brk};
    ev_valid_d = 1'b0;
    ev_break_d = 1'b0;
    ev_code_d  = '0;
    pressed_d  = 1'b0;
    unique case (s1_func_q)
      FN_SCAN: begin
        if (is_prefix) begin
          ext_d = 1'b1;
        end else begin
          ext_d      = 1'b0;
          map_wr.en  = fire;
          ev_valid_d = 1'b1;
          ev_break_d = brk;
          ev_code_d  = ext_q ? {ExtMark, kc} : {{(DataBits-KeyBits){1'b0}}, kc};
          if (kc == KcLshift || kc == KcRshift) begin
            shift_d = !brk;
          end
          if (!brk && kc == KcCaps) begin
            caps_d = !caps_q;
          end
        end
      end
      FN_QUERY: begin
        pressed_d = (s1_data_q[DataBits-1:KeyBits] == '0) && rd_pressed;
      end
      FN_XLAT:  ;
      FN_NONE:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      shift_q     <= 1'b0;
      caps_q      <= 1'b0;
      ext_q       <= 1'b0;
    end else begin
      if (!s1_valid_q || out_free) begin
        s1_valid_q <= accept;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (fire) begin
        shift_q <= shift_d;
        caps_q  <= caps_d;
        ext_q   <= ext_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q <= func_e'(func_i);
      s1_data_q <= data_i;
    end
    if (fire) begin
      ev_valid_q <= ev_valid_d;
      ev_break_q <= ev_break_d;
      ev_code_q  <= ev_code_d;
      pressed_q  <= pressed_d;
      ascii_q    <= (s1_func_q == FN_XLAT) ? xlat_char : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_valid_o = ev_valid_q;
  assign event_break_o = ev_break_q;
  assign event_code_o  = ev_code_q;
  assign pressed_o     = pressed_q;
  assign ascii_char_o  = ascii_q;

endmodule

`default_nettype wire
